>>> hw/rtl/kdb_pkg.sv
// Shared types, constants and helpers for the key debounce core.
// Used by kdb_step and key_debounce_short_long_press_core; no dependencies.
`timescale 1ns / 1ps

package kdb_pkg;

    localparam int unsigned TimerW   = 16;
    localparam int unsigned CodeW    = 8;
    localparam int unsigned CfgIdxW  = 2;
    localparam int unsigned CfgDataW = 16;
    localparam int unsigned OutDataW = 16;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_FILTER_TICKS = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_LONG_TICKS   = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_FREE_CODE    = 2'd2;

    // Register reset values
    localparam logic [TimerW-1:0] FILTER_TICKS_RST = 16'd2;
    localparam logic [TimerW-1:0] LONG_TICKS_RST   = 16'd100;
    localparam logic [CodeW-1:0]  FREE_CODE_RST    = 8'h00;

    // Scan sequencer steps
    typedef enum logic [1:0] {
        STEP_IDLE    = 2'd0,
        STEP_CONFIRM = 2'd1,
        STEP_HELD    = 2'd2,
        STEP_RELEASE = 2'd3
    } t_step;

    typedef struct packed {
        logic [TimerW-1:0] filter_ticks;
        logic [TimerW-1:0] long_ticks;
        logic [CodeW-1:0]  free_code;
    } t_cfg;

    typedef struct packed {
        logic             event_valid;
        logic             long_press;
        logic [CodeW-1:0] event_code;
    } t_result;

    // Saturating increment of a tick counter
    function automatic logic [TimerW-1:0] sat_inc(input logic [TimerW-1:0] v);
        sat_inc = (v == {TimerW{1'b1}}) ? v : v + {{(TimerW-1){1'b0}}, 1'b1};
    endfunction

endpackage

>>> hw/rtl/kdb_step.sv
// Debounce scan sequencer: tick counters, step register and event latches.
// Depends on kdb_pkg.
`timescale 1ns / 1ps

module kdb_step (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_advance,
    input  logic [kdb_pkg::CodeW-1:0]  i_key_code,
    input  kdb_pkg::t_cfg              i_cfg,
    output kdb_pkg::t_result           o_result
);

    kdb_pkg::t_step                r_step, n_step;
    logic [kdb_pkg::TimerW-1:0]    r_scan_elapsed, n_scan_elapsed;
    logic [kdb_pkg::TimerW-1:0]    r_hold_elapsed, n_hold_elapsed;
    logic [kdb_pkg::CodeW-1:0]     r_held_code, n_held_code;
    logic                          r_long_reported, n_long_reported;
    logic                          r_last_long, n_last_long;
    logic [kdb_pkg::CodeW-1:0]     r_last_code, n_last_code;
    logic                          w_event;
    logic [kdb_pkg::TimerW-1:0]    w_scan_inc;
    logic                          w_scan;

    // Advance the scan tick counter and decide whether this tick scans
    assign w_scan_inc = kdb_pkg::sat_inc(r_scan_elapsed);
    assign w_scan     = (w_scan_inc >= i_cfg.filter_ticks);

    // Next state of the scan sequencer
    always_comb begin
        n_step          = r_step;
        n_scan_elapsed  = w_scan ? '0 : w_scan_inc;
        n_hold_elapsed  = kdb_pkg::sat_inc(r_hold_elapsed);
        n_held_code     = r_held_code;
        n_long_reported = r_long_reported;
        n_last_long     = r_last_long;
        n_last_code     = r_last_code;
        w_event         = 1'b0;
        if (w_scan) begin
            unique case (r_step)
                kdb_pkg::STEP_IDLE: begin
                    if (i_key_code != i_cfg.free_code) begin
                        n_held_code = i_key_code;
                        n_step      = kdb_pkg::STEP_CONFIRM;
                    end
                end
                kdb_pkg::STEP_CONFIRM: begin
                    if (i_key_code == r_held_code) begin
                        n_step         = kdb_pkg::STEP_HELD;
                        n_hold_elapsed = '0;
                    end else begin
                        n_step = kdb_pkg::STEP_IDLE;
                    end
                end
                kdb_pkg::STEP_HELD: begin
                    // A match with the held key is tested before release
                    if (i_key_code == r_held_code) begin
                        if (!r_long_reported && (n_hold_elapsed >= i_cfg.long_ticks)) begin
                            w_event         = 1'b1;
                            n_last_long     = 1'b1;
                            n_last_code     = r_held_code;
                            n_long_reported = 1'b1;
                        end
                    end else if (i_key_code == i_cfg.free_code) begin
                        n_step = kdb_pkg::STEP_RELEASE;
                    end
                end
                kdb_pkg::STEP_RELEASE: begin
                    if (i_key_code == i_cfg.free_code) begin
                        if (!r_long_reported) begin
                            w_event     = 1'b1;
                            n_last_long = 1'b0;
                            n_last_code = r_held_code;
                        end
                        n_step          = kdb_pkg::STEP_IDLE;
                        n_long_reported = 1'b0;
                    end else begin
                        n_step = kdb_pkg::STEP_HELD;
                    end
                end
            endcase
        end
    end

    // Result of this tick
    always_comb begin
        o_result.event_valid = w_event;
        o_result.long_press  = n_last_long;
        o_result.event_code  = n_last_code;
    end

    // Commit state on each request taken from the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step          <= kdb_pkg::STEP_IDLE;
            r_scan_elapsed  <= '0;
            r_hold_elapsed  <= '0;
            r_held_code     <= '0;
            r_long_reported <= 1'b0;
            r_last_long     <= 1'b0;
            r_last_code     <= '0;
        end else if (i_advance) begin
            r_step          <= n_step;
            r_scan_elapsed  <= n_scan_elapsed;
            r_hold_elapsed  <= n_hold_elapsed;
            r_held_code     <= n_held_code;
            r_long_reported <= n_long_reported;
            r_last_long     <= n_last_long;
            r_last_code     <= n_last_code;
        end
    end

`ifndef SYNTHESIS
    // A long press is only ever reported from the held step
    a_long_from_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_event && n_last_long) |-> (r_step == kdb_pkg::STEP_HELD))
        else $error("long press event outside held step");

    // A short press is only reported on a confirmed release
    a_short_from_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && w_event && !n_last_long) |-> (r_step == kdb_pkg::STEP_RELEASE))
        else $error("short press event outside release step");

    // The long-press mark lives only while a key is held or releasing
    a_long_mark_scope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_long_reported |-> ((r_step == kdb_pkg::STEP_HELD) ||
                             (r_step == kdb_pkg::STEP_RELEASE)))
        else $error("long press mark set in idle or confirm step");
`endif

endmodule

>>> hw/rtl/key_debounce_short_long_press_core.sv
// A request in the input register reaches o_m_tvalid via the result register.
// Throughput: one request per cycle while i_m_tready is high; the input holds one more.
// The scan step is one pass through kdb_step between the input and result registers.
// Reset (synchronous, i_rst_n low): registers to defaults, scan idle, both stages empty.
// Top level of the key debounce core; depends on kdb_pkg and kdb_step.
`timescale 1ns / 1ps

module key_debounce_short_long_press_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port
    input  logic                          i_cfg_we,
    input  logic [kdb_pkg::CfgIdxW-1:0]   i_cfg_idx,
    input  logic [kdb_pkg::CfgDataW-1:0]  i_cfg_data,
    // Tick stream in
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [kdb_pkg::CodeW-1:0]     i_s_tdata,   // [7:0] key_code
    // Result stream out
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [kdb_pkg::OutDataW-1:0]  o_m_tdata    // [0] event_valid, [1] long_press,
                                                       // [9:2] event_code, [15:10] zero
);

    kdb_pkg::t_cfg                 r_cfg;
    logic                          r_in_valid;
    logic [kdb_pkg::CodeW-1:0]     r_in_key;
    logic                          r_out_valid;
    kdb_pkg::t_result              r_out;
    kdb_pkg::t_result              w_result;
    logic                          w_advance;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_ticks <= kdb_pkg::FILTER_TICKS_RST;
            r_cfg.long_ticks   <= kdb_pkg::LONG_TICKS_RST;
            r_cfg.free_code    <= kdb_pkg::FREE_CODE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                kdb_pkg::CFG_FILTER_TICKS: r_cfg.filter_ticks <= i_cfg_data;
                kdb_pkg::CFG_LONG_TICKS:   r_cfg.long_ticks   <= i_cfg_data;
                kdb_pkg::CFG_FREE_CODE:    r_cfg.free_code    <= i_cfg_data[kdb_pkg::CodeW-1:0];
                default: ;
            endcase
        end
    end

    // Move the held request on when the result register is free or draining
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_key <= i_s_tdata;
        end
    end

    kdb_step u_step (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (w_advance),
        .i_key_code (r_in_key),
        .i_cfg      (r_cfg),
        .o_result   (w_result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(kdb_pkg::OutDataW - kdb_pkg::CodeW - 2){1'b0}},
                         r_out.event_code, r_out.long_press, r_out.event_valid};

`ifndef SYNTHESIS
    // A request taken from the input register always lands in the result register
    a_advance_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("advanced request did not reach result register");

    // Back-pressure on the input only when the input register is occupied
    a_stall_means_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_in_valid && r_out_valid && !i_m_tready))
        else $error("input stalled without a blocked request");
`endif

endmodule

>>> sim/tb_key_debounce_short_long_press_core.sv
`timescale 1ns / 1ps
// Self-checking bench for key_debounce_short_long_press_core: streams ticks of key codes
// in, predicts press reports per tick and checks every result field. Depends on kdb_pkg.

module tb_key_debounce_short_long_press_core;

    localparam int unsigned TickLimit     = 400000;
    localparam int unsigned DrainCycles   = 8;
    localparam int unsigned HoldOffCycles = 90;
    // Index past the last register; writes to it must leave the block unchanged
    localparam logic [kdb_pkg::CfgIdxW-1:0] CFG_SPARE = 2'd3;

    typedef enum int {
        IDLE_RX_SLOW,
        IDLE_TX_SLOW,
        IDLE_NONE
    } t_idle;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_cfg_we   = 1'b0;
    logic [kdb_pkg::CfgIdxW-1:0]  i_cfg_idx  = '0;
    logic [kdb_pkg::CfgDataW-1:0] i_cfg_data = '0;
    logic                         i_s_tvalid = 1'b0;
    logic                         o_s_tready;
    logic [kdb_pkg::CodeW-1:0]    i_s_tdata  = '0;   // [7:0] key_code
    logic                         o_m_tvalid;
    logic                         i_m_tready = 1'b0;
    logic [kdb_pkg::OutDataW-1:0] o_m_tdata;         // [0] event_valid, [1] long_press,
                                                     // [9:2] event_code, [15:10] zero

    // Stimulus and expectation stores
    logic [kdb_pkg::CodeW-1:0] key_queue[$];
    kdb_pkg::t_result          pending_reports[$];
    int                        queued_items = 0;
    int                        errors       = 0;
    t_idle                     idle_mode    = IDLE_RX_SLOW;
    int                        holdoff_asks = 0;
    int                        holdoff_seen = 0;
    int                        holdoff_left = 0;

    // Predictor copy of the configuration
    logic [kdb_pkg::TimerW-1:0] flt_ticks = kdb_pkg::FILTER_TICKS_RST;
    logic [kdb_pkg::TimerW-1:0] lng_ticks = kdb_pkg::LONG_TICKS_RST;
    logic [kdb_pkg::CodeW-1:0]  idle_code = kdb_pkg::FREE_CODE_RST;

    // Predictor copy of the debounce state
    logic [kdb_pkg::TimerW-1:0] scan_cnt  = '0;
    kdb_pkg::t_step             step      = kdb_pkg::STEP_IDLE;
    logic [kdb_pkg::CodeW-1:0]  trk_code  = '0;
    logic [kdb_pkg::TimerW-1:0] hold_cnt  = '0;
    logic                       long_done = 1'b0;
    logic                       rep_long  = 1'b0;
    logic [kdb_pkg::CodeW-1:0]  rep_code  = '0;

    key_debounce_short_long_press_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Advance the debounce state by one tick and form the report for it
    task automatic debounce_tick(input logic [kdb_pkg::CodeW-1:0] key,
                                 output kdb_pkg::t_result r);
        r.event_valid = 1'b0;
        scan_cnt = (scan_cnt == '1) ? scan_cnt : scan_cnt + 1'b1;
        hold_cnt = (hold_cnt == '1) ? hold_cnt : hold_cnt + 1'b1;
        if (scan_cnt >= flt_ticks) begin
            scan_cnt = '0;
            case (step)
                kdb_pkg::STEP_IDLE: begin
                    if (key != idle_code) begin
                        trk_code = key;
                        step     = kdb_pkg::STEP_CONFIRM;
                    end
                end
                kdb_pkg::STEP_CONFIRM: begin
                    if (key == trk_code) begin
                        step     = kdb_pkg::STEP_HELD;
                        hold_cnt = '0;
                    end else begin
                        step = kdb_pkg::STEP_IDLE;
                    end
                end
                kdb_pkg::STEP_HELD: begin
                    // the tracked key wins over a changed free code
                    if (key == trk_code) begin
                        if (!long_done && hold_cnt >= lng_ticks) begin
                            r.event_valid = 1'b1;
                            rep_long      = 1'b1;
                            rep_code      = trk_code;
                            long_done     = 1'b1;
                        end
                    end else if (key == idle_code) begin
                        step = kdb_pkg::STEP_RELEASE;
                    end
                end
                default: begin
                    if (key == idle_code) begin
                        if (!long_done) begin
                            r.event_valid = 1'b1;
                            rep_long      = 1'b0;
                            rep_code      = trk_code;
                        end
                        step      = kdb_pkg::STEP_IDLE;
                        long_done = 1'b0;
                    end else begin
                        step = kdb_pkg::STEP_HELD;
                    end
                end
            endcase
        end
        r.long_press = rep_long;
        r.event_code = rep_code;
    endtask

    function automatic bit tx_gap();
        case (idle_mode)
            IDLE_RX_SLOW: return $urandom_range(0, 99) < 7;
            IDLE_TX_SLOW: return $urandom_range(0, 99) < 83;
            default:      return 1'b0;
        endcase
    endfunction

    function automatic bit rx_stall();
        case (idle_mode)
            IDLE_RX_SLOW: return $urandom_range(0, 99) < 83;
            IDLE_TX_SLOW: return $urandom_range(0, 99) < 7;
            default:      return 1'b0;
        endcase
    endfunction

    // Offer queued ticks; predict each request as it is taken
    always @(posedge i_clk) begin : tick_driver
        kdb_pkg::t_result r;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                debounce_tick(i_s_tdata, r);
                pending_reports.push_back(r);
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (key_queue.size() > 0 && !tx_gap()) begin
                    i_s_tvalid <= 1'b1;
                    i_s_tdata  <= key_queue.pop_front();
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Drive result-side ready; a hold-off request blocks it for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready   <= 1'b0;
            holdoff_seen <= 0;
            holdoff_left <= 0;
        end else if (holdoff_asks != holdoff_seen) begin
            holdoff_seen <= holdoff_asks;
            holdoff_left <= HoldOffCycles;
            i_m_tready   <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            i_m_tready   <= 1'b0;
        end else begin
            i_m_tready <= !rx_stall();
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge i_clk) begin : report_checker
        kdb_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, o_m_tdata);
                errors++;
            end else begin
                want = pending_reports.pop_front();
                if (o_m_tdata[0] !== want.event_valid) begin
                    $display("%0t: event_valid expected %b actual %b",
                             $time, want.event_valid, o_m_tdata[0]);
                    errors++;
                end
                if (o_m_tdata[1] !== want.long_press) begin
                    $display("%0t: long_press expected %b actual %b",
                             $time, want.long_press, o_m_tdata[1]);
                    errors++;
                end
                if (o_m_tdata[kdb_pkg::CodeW+1:2] !== want.event_code) begin
                    $display("%0t: event_code expected %h actual %h",
                             $time, want.event_code, o_m_tdata[kdb_pkg::CodeW+1:2]);
                    errors++;
                end
                if (o_m_tdata[kdb_pkg::OutDataW-1:kdb_pkg::CodeW+2] !== '0) begin
                    $display("%0t: padding expected 0 actual %h",
                             $time, o_m_tdata[kdb_pkg::OutDataW-1:kdb_pkg::CodeW+2]);
                    errors++;
                end
            end
        end
    end

    task automatic push_run(input logic [kdb_pkg::CodeW-1:0] k, input int n);
        repeat (n) key_queue.push_back(k);
        queued_items += n;
    endtask

    // Draw any key code
    function automatic logic [kdb_pkg::CodeW-1:0] rand_code();
        int unsigned v;
        v = $urandom_range(0, 255);
        return v[kdb_pkg::CodeW-1:0];
    endfunction

    function automatic logic [kdb_pkg::CodeW-1:0] pick_key();
        logic [kdb_pkg::CodeW-1:0] k;
        k = rand_code();
        while (k == idle_code) k = rand_code();
        return k;
    endfunction

    // Queue mostly well-formed presses with random timing, plus some raw noise
    task automatic queue_presses(input int n_items);
        int                        stride;
        int                        target;
        logic [kdb_pkg::CodeW-1:0] k;
        stride = (flt_ticks < 2) ? 1 : int'(flt_ticks);
        target = queued_items + n_items;
        while (queued_items < target) begin
            k = pick_key();
            if ($urandom_range(0, 99) < 80) begin
                push_run(idle_code, $urandom_range(0, 2 * stride));
                // contact bounce before the key settles
                if ($urandom_range(0, 4) == 0) begin
                    push_run(k, $urandom_range(1, stride));
                    push_run(idle_code, $urandom_range(1, stride));
                end
                if ($urandom_range(0, 2) == 0)
                    push_run(k, $urandom_range(1, 3 * stride));
                else
                    push_run(k, $urandom_range(1, int'(lng_ticks) + 4 * stride + 4));
                // a second key pressed while the first is held
                if ($urandom_range(0, 5) == 0) begin
                    push_run(pick_key(), $urandom_range(1, stride));
                    push_run(k, $urandom_range(1, 2 * stride));
                end
                push_run(idle_code, $urandom_range(1, 3 * stride));
                // glitch during release
                if ($urandom_range(0, 5) == 0) begin
                    push_run(pick_key(), 1);
                    push_run(idle_code, $urandom_range(1, 3 * stride));
                end
            end else begin
                repeat ($urandom_range(1, 4)) push_run(rand_code(), 1);
            end
        end
    endtask

    // Hold until every tick is taken and every report has come back; sample between edges
    task automatic drain();
        while (key_queue.size() != 0 || i_s_tvalid || pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [kdb_pkg::CfgIdxW-1:0] idx,
                           input logic [kdb_pkg::CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            kdb_pkg::CFG_FILTER_TICKS: flt_ticks = val;
            kdb_pkg::CFG_LONG_TICKS:   lng_ticks = val;
            kdb_pkg::CFG_FREE_CODE:    idle_code = val[kdb_pkg::CodeW-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(input logic [kdb_pkg::TimerW-1:0] f,
                             input logic [kdb_pkg::TimerW-1:0] l,
                             input logic [kdb_pkg::CodeW-1:0] c);
        set_reg(kdb_pkg::CFG_FILTER_TICKS, f);
        set_reg(kdb_pkg::CFG_LONG_TICKS, l);
        set_reg(kdb_pkg::CFG_FREE_CODE, {{(kdb_pkg::CfgDataW-kdb_pkg::CodeW){1'b0}}, c});
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_phase(input t_idle mode, input int n_items, input bit squeeze);
        idle_mode = mode;
        @(negedge i_clk);
        queue_presses(n_items);
        if (squeeze) holdoff_asks++;
        drain();
    endtask

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Short press under the reset settings
        idle_mode = IDLE_RX_SLOW;
        @(negedge i_clk);
        push_run(8'h00, 2);
        push_run(8'hA5, 6);
        push_run(8'h00, 6);
        drain();

        // Scan every tick, long press at once, stray key, another key during release
        set_reg(CFG_SPARE, 16'hFFFF);
        configure(16'd0, 16'd0, 8'hFF);
        @(negedge i_clk);
        push_run(8'hFF, 2);
        push_run(8'h00, 4);
        push_run(8'h5A, 1);
        push_run(8'hFF, 1);
        push_run(8'h33, 1);
        push_run(8'hFF, 3);
        drain();

        configure(16'd1, 16'd20, 8'h00);
        run_phase(IDLE_RX_SLOW, 300, 1'b1);
        configure(16'd3, 16'd7, rand_code());
        run_phase(IDLE_RX_SLOW, 250, 1'b0);
        configure(16'd0, 16'd30, 8'h80);
        run_phase(IDLE_TX_SLOW, 300, 1'b1);
        configure(16'd5, 16'd1, rand_code());
        run_phase(IDLE_TX_SLOW, 250, 1'b0);

        // Widest timer settings: no scan can fall inside this short burst
        configure(16'hFFFF, 16'hFFFF, 8'hFF);
        idle_mode = IDLE_NONE;
        @(negedge i_clk);
        repeat (30) push_run(rand_code(), 1);
        drain();

        configure(16'd2, 16'd12, rand_code());
        run_phase(IDLE_NONE, 300, 1'b1);
        configure(16'd1, 16'd0, rand_code());
        run_phase(IDLE_NONE, 250, 1'b0);

        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Give up if the run stalls
    initial begin : watchdog
        repeat (TickLimit) @(posedge i_clk);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
